### hw/rtl/ddmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmc_pkg
// Shared codes, widths and types of the differential drive motion controller.
// ----------------------------------------------------------------------------
package ddmc_pkg;

	localparam int ACTION_W   = 3;
	localparam int MOTION_W   = 4;
	localparam int SPEED_W    = 8;
	localparam int DURATION_W = 32;
	localparam int DUTY_W     = 8;

	localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST = 8'd200;

	// event codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_DRIVE  = 3'd0,
		ACT_TIMED  = 3'd1,
		ACT_STOP   = 3'd2,
		ACT_LOCK   = 3'd3,
		ACT_UNLOCK = 3'd4,
		ACT_TICK   = 3'd5
	} action_t;

	// motion codes
	localparam logic [MOTION_W-1:0] MOT_STOP   = 4'd0;
	localparam logic [MOTION_W-1:0] MOT_FWD    = 4'd1;
	localparam logic [MOTION_W-1:0] MOT_BACK   = 4'd2;
	localparam logic [MOTION_W-1:0] MOT_PIVOTL = 4'd3;
	localparam logic [MOTION_W-1:0] MOT_PIVOTR = 4'd4;
	localparam logic [MOTION_W-1:0] MOT_TURNL  = 4'd5;
	localparam logic [MOTION_W-1:0] MOT_TURNR  = 4'd6;
	localparam logic [MOTION_W-1:0] MOT_CURVEL = 4'd7;
	localparam logic [MOTION_W-1:0] MOT_CURVER = 4'd8;

	// motion state seen by the wheel mixer and the status outputs
	typedef struct packed {
		logic [MOTION_W-1:0] motion;
		logic [SPEED_W-1:0]  speed;
		logic                locked;
		logic                timed;
	} ddmc_state_t;

	// H-bridge duties of both wheels
	typedef struct packed {
		logic [DUTY_W-1:0] left_fwd;
		logic [DUTY_W-1:0] left_back;
		logic [DUTY_W-1:0] right_fwd;
		logic [DUTY_W-1:0] right_back;
	} ddmc_duty_t;

endpackage

### hw/rtl/ddmc_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmc_state
// Motion state registers and the event decode that updates them; presents
// the state as it stands after the current event.
// ----------------------------------------------------------------------------
module ddmc_state import ddmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [ACTION_W-1:0]   action,
	input  logic [MOTION_W-1:0]   motion,
	input  logic [SPEED_W-1:0]    speed,
	input  logic [DURATION_W-1:0] duration_ms,
	input  logic [SPEED_W-1:0]    default_speed,
	output ddmc_state_t           state_next
);

	ddmc_state_t           state_q;
	logic [DURATION_W-1:0] elapsed_q;
	logic [DURATION_W-1:0] duration_q;
	logic [DURATION_W-1:0] elapsed_next;
	logic [DURATION_W-1:0] duration_next;
	logic [MOTION_W-1:0]   motion_eff;
	logic [SPEED_W-1:0]    speed_eff;
	logic [DURATION_W-1:0] elapsed_inc;

	// fold unused motion codes to stop, apply the default speed
	assign motion_eff  = (motion > MOT_CURVER) ? MOT_STOP : motion;
	assign speed_eff   = (speed == '0) ? default_speed : speed;
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	// decode the event against the current state
	always_comb begin
		state_next    = state_q;
		elapsed_next  = elapsed_q;
		duration_next = duration_q;
		case (action)
			ACT_DRIVE: begin
				if (!state_q.locked) begin
					state_next.timed  = 1'b0;
					state_next.motion = motion_eff;
					state_next.speed  = speed_eff;
				end
			end
			ACT_TIMED: begin
				if (!state_q.locked) begin
					state_next.timed  = 1'b1;
					state_next.motion = motion_eff;
					state_next.speed  = speed_eff;
					elapsed_next      = '0;
					duration_next     = duration_ms;
				end
			end
			ACT_STOP: begin
				state_next.timed  = 1'b0;
				state_next.motion = MOT_STOP;
				state_next.speed  = '0;
			end
			ACT_LOCK: begin
				state_next.locked = 1'b1;
				state_next.timed  = 1'b0;
				state_next.motion = MOT_STOP;
				state_next.speed  = '0;
			end
			ACT_UNLOCK: begin
				state_next.locked = 1'b0;
			end
			ACT_TICK: begin
				if (state_q.timed) begin
					elapsed_next = elapsed_inc;
					if (elapsed_inc >= duration_q) begin
						state_next.timed  = 1'b0;
						state_next.motion = MOT_STOP;
						state_next.speed  = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// commit the event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '0;
			elapsed_q  <= '0;
			duration_q <= '0;
		end else if (step) begin
			state_q    <= state_next;
			elapsed_q  <= elapsed_next;
			duration_q <= duration_next;
		end
	end

endmodule

### hw/rtl/ddmc_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddmc_mix
// Wheel mixer: maps motion and speed to signed wheel speeds and splits each
// into forward and backward H-bridge duty.
// ----------------------------------------------------------------------------
module ddmc_mix import ddmc_pkg::*; (
	input  ddmc_state_t state,
	output ddmc_duty_t  duty
);

	logic [SPEED_W-1:0] full_spd;
	logic [SPEED_W-1:0] half_spd;
	logic [SPEED_W-1:0] left_mag;
	logic [SPEED_W-1:0] right_mag;
	logic               left_rev;
	logic               right_rev;

	assign full_spd = state.speed;
	assign half_spd = state.speed >> 1;

	// pick magnitude and direction per wheel
	always_comb begin
		left_mag  = '0;
		right_mag = '0;
		left_rev  = 1'b0;
		right_rev = 1'b0;
		case (state.motion)
			MOT_FWD: begin
				left_mag  = full_spd;
				right_mag = full_spd;
			end
			MOT_BACK: begin
				left_mag  = full_spd;
				right_mag = full_spd;
				left_rev  = 1'b1;
				right_rev = 1'b1;
			end
			MOT_PIVOTL: begin
				left_mag  = full_spd;
				right_mag = full_spd;
				left_rev  = 1'b1;
			end
			MOT_PIVOTR: begin
				left_mag  = full_spd;
				right_mag = full_spd;
				right_rev = 1'b1;
			end
			MOT_TURNL: begin
				right_mag = full_spd;
			end
			MOT_TURNR: begin
				left_mag = full_spd;
			end
			MOT_CURVEL: begin
				left_mag  = half_spd;
				right_mag = full_spd;
			end
			MOT_CURVER: begin
				left_mag  = full_spd;
				right_mag = half_spd;
			end
			default: begin
			end
		endcase
	end

	// split into H-bridge legs
	assign duty.left_fwd   = left_rev  ? '0 : left_mag;
	assign duty.left_back  = left_rev  ? left_mag : '0;
	assign duty.right_fwd  = right_rev ? '0 : right_mag;
	assign duty.right_back = right_rev ? right_mag : '0;

endmodule

### hw/rtl/differential_drive_motion_controller.sv
`timescale 1ns / 1ps
// Takes one motion event per clock while in_stall is low (drive, timed drive,
// stop, lock, unlock, millisecond tick) and returns one result beat per event
// with the wheel duties and status after that event; a held out_stall backs up
// into in_stall. Each event passes the input register and then the result
// register, with the state decode and the wheel mixer between them. The
// default speed register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
// differential_drive_motion_controller
// Top level: input register, motion state, wheel mixer and result register.
// ----------------------------------------------------------------------------
module differential_drive_motion_controller import ddmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [SPEED_W-1:0]    cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [MOTION_W-1:0]   motion,
	input  logic [SPEED_W-1:0]    speed,
	input  logic [DURATION_W-1:0] duration_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DUTY_W-1:0]     left_fwd_duty,
	output logic [DUTY_W-1:0]     left_back_duty,
	output logic [DUTY_W-1:0]     right_fwd_duty,
	output logic [DUTY_W-1:0]     right_back_duty,
	output logic [MOTION_W-1:0]   motion_now,
	output logic                  moving,
	output logic                  is_locked,
	output logic                  timed_busy
);

	logic [SPEED_W-1:0]    default_speed_q;
	logic                  valid_s1;
	logic [ACTION_W-1:0]   action_s1;
	logic [MOTION_W-1:0]   motion_s1;
	logic [SPEED_W-1:0]    speed_s1;
	logic [DURATION_W-1:0] duration_s1;
	logic                  valid_s2;
	ddmc_state_t           state_s2;
	ddmc_duty_t            duty_s2;
	logic                  ready_s1;
	logic                  adv_s2;
	ddmc_state_t           state_next;
	ddmc_duty_t            duty_next;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_speed_q <= DEFAULT_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			default_speed_q <= cfg_data;
		end
	end

	// pipeline flow control
	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign ready_s1 = !valid_s1 || adv_s2;
	assign in_stall = !ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			action_s1   <= action;
			motion_s1   <= motion;
			speed_s1    <= speed;
			duration_s1 <= duration_ms;
		end
	end

	// state update and wheel mix
	ddmc_state u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv_s2),
		.action        (action_s1),
		.motion        (motion_s1),
		.speed         (speed_s1),
		.duration_ms   (duration_s1),
		.default_speed (default_speed_q),
		.state_next    (state_next)
	);

	ddmc_mix u_mix (
		.state (state_next),
		.duty  (duty_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			state_s2 <= state_next;
			duty_s2  <= duty_next;
		end
	end

	assign out_valid       = valid_s2;
	assign left_fwd_duty   = duty_s2.left_fwd;
	assign left_back_duty  = duty_s2.left_back;
	assign right_fwd_duty  = duty_s2.right_fwd;
	assign right_back_duty = duty_s2.right_back;
	assign motion_now      = state_s2.motion;
	assign moving          = (state_s2.motion != MOT_STOP);
	assign is_locked       = state_s2.locked;
	assign timed_busy      = state_s2.timed;

`ifndef SYNTH
	// a timed move never runs under lock
	a_timed_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_busy |-> !is_locked)
		else $error("timed move reported while locked");

	// one H-bridge leg per wheel at a time
	a_left_leg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (left_fwd_duty != '0) |-> (left_back_duty == '0))
		else $error("left wheel drives both legs");

	a_right_leg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (right_fwd_duty != '0) |-> (right_back_duty == '0))
		else $error("right wheel drives both legs");

	// a stopped robot has no duty on any leg
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !moving |-> (left_fwd_duty == '0) && (left_back_duty == '0)
			&& (right_fwd_duty == '0) && (right_back_duty == '0))
		else $error("duty present while stopped");
`endif

endmodule
